@@ rtl/pomppt_pkg.sv @@
// ----------------------------------------------------------------------------
// pomppt_pkg
// Shared types and constants for the perturb-and-observe MPPT tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package pomppt_pkg;

    localparam int NUM_CHANNELS_DEF = 8;
    localparam int CODE_BITS_DEF    = 12;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int COUNT_W    = 16;   // per-channel sample counter
    localparam int ROUND_BITS = 24;   // Q.40 product down to Q.16

    localparam logic signed [63:0] PWR_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] PWR_MIN = 64'sh8000_0000_0000_0000;

    localparam logic [15:0] TRACK_INTERVAL_RST  = 16'd100;
    localparam logic [15:0] REPORT_INTERVAL_RST = 16'd1000;
    localparam logic [11:0] VOLTAGE_STEP_RST    = 12'd1;
    localparam logic [31:0] SLOPE_RST           = 32'h0010_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TRACK_INTERVAL  = 3'd0,
        CFG_REPORT_INTERVAL = 3'd1,
        CFG_VOLTAGE_STEP    = 3'd2,
        CFG_CURRENT_SLOPE   = 3'd3,
        CFG_CURRENT_OFFSET  = 3'd4,
        CFG_VOLTAGE_SLOPE   = 3'd5,
        CFG_VOLTAGE_OFFSET  = 3'd6
    } t_cfg_reg;

    typedef enum logic {
        OP_TRACK = 1'b0,
        OP_SET   = 1'b1
    } t_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_SCALE_I,
        S_SCALE_V,
        S_MUL_START,
        S_MUL_WAIT,
        S_POWER,
        S_DIFF,
        S_DECIDE,
        S_NUMER,
        S_DIV_START,
        S_DIV_WAIT,
        S_UPDATE,
        S_EMIT
    } t_state;

endpackage

`default_nettype wire

@@ rtl/pomppt_ser_mul.sv @@
// ----------------------------------------------------------------------------
// pomppt_ser_mul
// Bit-serial unsigned shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pomppt_ser_mul #(
    parameter int W = 44
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_start,
    input  wire logic [W-1:0]   i_a,
    input  wire logic [W-1:0]   i_b,
    output logic                o_done,
    output logic [2*W-1:0]      o_prod
);

    localparam int CNT_W = $clog2(W + 1);

    logic [2*W-1:0]   r_acc;
    logic [W-1:0]     r_mcand;
    logic [CNT_W-1:0] r_cnt;
    logic             r_done;
    logic [W:0]       w_sum;

    assign w_sum = {1'b0, r_acc[2*W-1:W]} + (r_acc[0] ? {1'b0, r_mcand} : {(W+1){1'b0}});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_acc   <= {{W{1'b0}}, i_b};
                r_mcand <= i_a;
                r_cnt   <= CNT_W'(W);
            end else if (r_cnt != '0) begin
                r_acc  <= {w_sum, r_acc[W-1:1]};
                r_cnt  <= r_cnt - 1'b1;
                r_done <= (r_cnt == CNT_W'(1));
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

`default_nettype wire

@@ rtl/pomppt_ser_div.sv @@
// ----------------------------------------------------------------------------
// pomppt_ser_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pomppt_ser_div #(
    parameter int N = 29,
    parameter int D = 17
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_start,
    input  wire logic [N-1:0]   i_num,
    input  wire logic [D-1:0]   i_den,
    output logic                o_done,
    output logic [N-1:0]        o_quo
);

    localparam int CNT_W = $clog2(N + 1);

    logic [D-1:0]     r_rem;
    logic [N-1:0]     r_quo;
    logic [D-1:0]     r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_done;
    logic [D:0]       w_sh;
    logic [D:0]       w_diff;
    logic             w_ge;

    assign w_sh   = {r_rem, r_quo[N-1]};
    assign w_ge   = (w_sh >= {1'b0, r_den});
    assign w_diff = w_sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rem <= '0;
                r_quo <= i_num;
                r_den <= i_den;
                r_cnt <= CNT_W'(N);
            end else if (r_cnt != '0) begin
                r_rem  <= w_ge ? w_diff[D-1:0] : w_sh[D-1:0];
                r_quo  <= {r_quo[N-2:0], w_ge};
                r_cnt  <= r_cnt - 1'b1;
                r_done <= (r_cnt == CNT_W'(1));
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

`default_nettype wire

@@ rtl/perturb_observe_mppt_tracker.sv @@
// ----------------------------------------------------------------------------
// perturb_observe_mppt_tracker
// Per-channel perturb-and-observe MPPT with running voltage/current stats.
//
// One transaction at a time. A tracking sample scales the current ADC code and
// the channel's DAC code to Q.20 current and voltage, forms their power through
// a bit-serial multiplier (one bit per cycle over max(CODE_BITS,12)+32 bits),
// compares it with the channel's reference power and steps the DAC code; the
// running means come from two restoring dividers run side by side, one bit per
// cycle over max(CODE_BITS,12)+17 bits. The time a tracking sample takes from
// acceptance to result is set almost entirely by those two serial units. A
// direct DAC set goes from decode straight to the emit state. A sample that
// is ignored (channel out of range or track interval not yet elapsed) gives
// no result and goes from decode straight back to idle. The result sits in
// an output register, so the next transaction is taken while it waits.
// ----------------------------------------------------------------------------
`default_nettype none

module perturb_observe_mppt_tracker #(
    parameter int NUM_CHANNELS = pomppt_pkg::NUM_CHANNELS_DEF,
    parameter int CODE_BITS    = pomppt_pkg::CODE_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    // sample channel
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic        i_operation,
    input  wire logic [2:0]  i_channel,
    input  wire logic [31:0] i_time_ms,
    input  wire logic [11:0] i_current_code,
    input  wire logic [11:0] i_set_code,

    // result channel
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [2:0]       o_out_channel,
    output logic [11:0]      o_dac_code,
    output logic             o_report_valid,
    output logic [11:0]      o_mean_voltage,
    output logic [11:0]      o_mean_current,
    output logic [11:0]      o_min_voltage,
    output logic [11:0]      o_max_voltage,
    output logic [11:0]      o_min_current,
    output logic [11:0]      o_max_current,

    // configuration write port
    input  wire logic                                i_cfg_we,
    input  wire logic [pomppt_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [pomppt_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int CW    = CODE_BITS;
    localparam int SW    = (CODE_BITS > 12) ? CODE_BITS : 12;  // stats width
    localparam int CHI_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int LW    = SW + 33;          // signed scaled I / V
    localparam int MW    = SW + 32;          // magnitude of scaled I / V
    localparam int PW    = 2 * MW;           // product magnitude
    localparam int QW    = PW + 1 - pomppt_pkg::ROUND_BITS;
    localparam int NW    = SW + 17;          // mean numerator
    localparam int DW    = pomppt_pkg::COUNT_W + 1;
    localparam logic [CW-1:0] CODE_MAX = '1;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [15:0]        r_cfg_track;
    logic [15:0]        r_cfg_report;
    logic [11:0]        r_cfg_step;
    logic signed [31:0] r_cfg_islope;
    logic signed [31:0] r_cfg_ioffset;
    logic signed [31:0] r_cfg_vslope;
    logic signed [31:0] r_cfg_voffset;

    // ------------------------------------------------------------------
    // Per-channel state
    // ------------------------------------------------------------------
    logic [31:0]        r_last_trk  [NUM_CHANNELS];
    logic [31:0]        r_last_rep  [NUM_CHANNELS];
    logic [CW-1:0]      r_dac       [NUM_CHANNELS];
    logic [CW-1:0]      r_prev_dac  [NUM_CHANNELS];
    logic signed [63:0] r_ref_pwr   [NUM_CHANNELS];
    logic [pomppt_pkg::COUNT_W-1:0] r_cnt [NUM_CHANNELS];
    logic [SW-1:0]      r_vavg      [NUM_CHANNELS];
    logic [SW-1:0]      r_iavg      [NUM_CHANNELS];
    logic [SW-1:0]      r_vlow      [NUM_CHANNELS];
    logic [SW-1:0]      r_vhigh     [NUM_CHANNELS];
    logic [SW-1:0]      r_ilow      [NUM_CHANNELS];
    logic [SW-1:0]      r_ihigh     [NUM_CHANNELS];

    // ------------------------------------------------------------------
    // Transaction and working registers
    // ------------------------------------------------------------------
    pomppt_pkg::t_state r_state, n_state;
    pomppt_pkg::t_op    r_op;
    logic [2:0]         r_chan_in;
    logic [31:0]        r_time;
    logic [11:0]        r_icode;
    logic [11:0]        r_scode;

    logic [CW-1:0]      r_v;
    logic [CW-1:0]      r_prev;
    logic signed [63:0] r_ref;
    logic [pomppt_pkg::COUNT_W-1:0] r_n;
    logic [SW-1:0]      r_avg_v, r_avg_i;
    logic [SW-1:0]      r_vlo, r_vhi, r_ilo, r_ihi;
    logic signed [LW-1:0] r_cur, r_vol;
    logic signed [63:0] r_pw;
    logic [63:0]        r_diff;
    logic               r_up;
    logic               r_ref_we;
    logic [NW-1:0]      r_num_v, r_num_i;

    // staged result
    logic [CW-1:0]      r_res_dac;
    logic               r_res_rep;
    logic [SW-1:0]      r_res_mv, r_res_mi, r_res_vlo, r_res_vhi, r_res_ilo, r_res_ihi;

    // output register
    logic               r_o_valid;
    logic [2:0]         r_out_ch;
    logic [CW-1:0]      r_out_dac;
    logic               r_out_rep;
    logic [SW-1:0]      r_out_mv, r_out_mi, r_out_vlo, r_out_vhi, r_out_ilo, r_out_ihi;

    // ------------------------------------------------------------------
    // Datapath wires
    // ------------------------------------------------------------------
    logic [CHI_W-1:0]     w_ch;
    logic                 w_in_range;
    logic                 w_early;
    logic [CW-1:0]        w_set_code;
    logic signed [LW-1:0] w_cur_full, w_vol_full;
    logic [MW-1:0]        w_cur_mag, w_vol_mag;
    logic                 w_neg;
    logic                 w_mul_start, w_mul_done;
    logic [PW-1:0]        w_prod;
    logic [PW:0]          w_rnd;
    logic [QW-1:0]        w_q;
    logic                 w_sat;
    logic signed [63:0]   w_pw;
    logic [67:0]          w_ten_diff;
    logic                 w_large;
    logic                 w_same, w_rising;
    logic [SW-1:0]        w_v_ext, w_i_ext;
    logic [NW-1:0]        w_num_v, w_num_i;
    logic                 w_div_start, w_div_done_v, w_div_done_i;
    logic [NW-1:0]        w_quo_v, w_quo_i;
    logic [DW-1:0]        w_den;
    logic [SW-1:0]        w_avg_v_new, w_avg_i_new;
    logic [SW-1:0]        w_vlo_new, w_vhi_new, w_ilo_new, w_ihi_new;
    logic                 w_report;
    logic [SW:0]          w_up_sum;
    logic [CW-1:0]        w_next;
    logic                 w_emit;

    assign w_ch       = CHI_W'(r_chan_in);
    assign w_in_range = ({29'd0, r_chan_in} < 32'(NUM_CHANNELS));
    assign w_early    = ((r_time - r_last_trk[w_ch]) < {16'd0, r_cfg_track});
    assign w_set_code = CW'(r_scode);

    // Q.20 scaling: code * slope + offset
    assign w_cur_full = $signed({1'b0, r_icode}) * r_cfg_islope + r_cfg_ioffset;
    assign w_vol_full = $signed({1'b0, r_v}) * r_cfg_vslope + r_cfg_voffset;
    assign w_cur_mag  = MW'(r_cur[LW-1] ? -r_cur : r_cur);
    assign w_vol_mag  = MW'(r_vol[LW-1] ? -r_vol : r_vol);
    assign w_neg      = r_cur[LW-1] ^ r_vol[LW-1];

    pomppt_ser_mul #(.W(MW)) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (w_cur_mag),
        .i_b     (w_vol_mag),
        .o_done  (w_mul_done),
        .o_prod  (w_prod)
    );

    // floor toward minus infinity: round the magnitude up when negative
    assign w_rnd = {1'b0, w_prod} + (PW+1)'({pomppt_pkg::ROUND_BITS{w_neg}});
    assign w_q   = w_rnd[PW:pomppt_pkg::ROUND_BITS];
    assign w_sat = |w_q[QW-1:63];
    assign w_pw  = w_sat ? (w_neg ? pomppt_pkg::PWR_MIN : pomppt_pkg::PWR_MAX)
                         : (w_neg ? -$signed(w_q[63:0]) : $signed(w_q[63:0]));

    // large fall: ref zero, or ref positive and 10 * (ref - pw) > ref
    assign w_ten_diff = {1'b0, r_diff, 3'b000} + {3'b000, r_diff, 1'b0};
    assign w_large    = (r_ref == 64'sd0) ||
                        (!r_ref[63] && (w_ten_diff > {4'd0, r_ref}));
    assign w_same     = (r_v == r_prev);
    assign w_rising   = (r_v > r_prev);

    // running means
    assign w_v_ext = SW'(r_v);
    assign w_i_ext = SW'(r_icode);
    assign w_num_v = NW'(r_avg_v) * NW'(r_n) + NW'(w_v_ext);
    assign w_num_i = NW'(r_avg_i) * NW'(r_n) + NW'(w_i_ext);
    assign w_den   = DW'(r_n) + DW'(1);

    pomppt_ser_div #(.N(NW), .D(DW)) u_div_v (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (r_num_v),
        .i_den   (w_den),
        .o_done  (w_div_done_v),
        .o_quo   (w_quo_v)
    );

    pomppt_ser_div #(.N(NW), .D(DW)) u_div_i (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (r_num_i),
        .i_den   (w_den),
        .o_done  (w_div_done_i),
        .o_quo   (w_quo_i)
    );

    assign w_avg_v_new = SW'(w_quo_v);
    assign w_avg_i_new = SW'(w_quo_i);
    assign w_vhi_new   = (w_v_ext > r_vhi) ? w_v_ext : r_vhi;
    assign w_vlo_new   = (w_v_ext < r_vlo) ? w_v_ext : r_vlo;
    assign w_ihi_new   = (w_i_ext > r_ihi) ? w_i_ext : r_ihi;
    assign w_ilo_new   = (w_i_ext < r_ilo) ? w_i_ext : r_ilo;
    assign w_report    = ((r_time - r_last_rep[w_ch]) > {16'd0, r_cfg_report});

    // DAC step with saturation to 0..CODE_MAX
    assign w_up_sum = (SW+1)'(r_v) + (SW+1)'(r_cfg_step);
    always_comb begin
        if (r_up) begin
            w_next = (w_up_sum > (SW+1)'(CODE_MAX)) ? CODE_MAX : CW'(w_up_sum);
        end else if ((SW+1)'(r_cfg_step) > (SW+1)'(r_v)) begin
            w_next = '0;
        end else begin
            w_next = CW'((SW+1)'(r_v) - (SW+1)'(r_cfg_step));
        end
    end

    // ------------------------------------------------------------------
    // Controller: next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pomppt_pkg::S_IDLE: begin
                if (i_valid) n_state = pomppt_pkg::S_DECODE;
            end
            pomppt_pkg::S_DECODE: begin
                priority if (!w_in_range)               n_state = pomppt_pkg::S_IDLE;
                else if (r_op == pomppt_pkg::OP_SET)    n_state = pomppt_pkg::S_EMIT;
                else if (w_early)                       n_state = pomppt_pkg::S_IDLE;
                else                                    n_state = pomppt_pkg::S_SCALE_I;
            end
            pomppt_pkg::S_SCALE_I:   n_state = pomppt_pkg::S_SCALE_V;
            pomppt_pkg::S_SCALE_V:   n_state = pomppt_pkg::S_MUL_START;
            pomppt_pkg::S_MUL_START: n_state = pomppt_pkg::S_MUL_WAIT;
            pomppt_pkg::S_MUL_WAIT: begin
                if (w_mul_done) n_state = pomppt_pkg::S_POWER;
            end
            pomppt_pkg::S_POWER:     n_state = pomppt_pkg::S_DIFF;
            pomppt_pkg::S_DIFF:      n_state = pomppt_pkg::S_DECIDE;
            pomppt_pkg::S_DECIDE:    n_state = pomppt_pkg::S_NUMER;
            pomppt_pkg::S_NUMER:     n_state = pomppt_pkg::S_DIV_START;
            pomppt_pkg::S_DIV_START: n_state = pomppt_pkg::S_DIV_WAIT;
            pomppt_pkg::S_DIV_WAIT: begin
                if (w_div_done_v && w_div_done_i) n_state = pomppt_pkg::S_UPDATE;
            end
            pomppt_pkg::S_UPDATE:    n_state = pomppt_pkg::S_EMIT;
            pomppt_pkg::S_EMIT: begin
                if (w_emit) n_state = pomppt_pkg::S_IDLE;
            end
            default:                 n_state = pomppt_pkg::S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Controller: outputs
    // ------------------------------------------------------------------
    always_comb begin
        o_stall     = 1'b1;
        w_mul_start = 1'b0;
        w_div_start = 1'b0;
        w_emit      = 1'b0;
        unique case (r_state)
            pomppt_pkg::S_IDLE:      o_stall     = 1'b0;
            pomppt_pkg::S_MUL_START: w_mul_start = 1'b1;
            pomppt_pkg::S_DIV_START: w_div_start = 1'b1;
            pomppt_pkg::S_EMIT:      w_emit      = !r_o_valid || !i_stall;
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= pomppt_pkg::S_IDLE;
            r_o_valid     <= 1'b0;
            r_cfg_track   <= pomppt_pkg::TRACK_INTERVAL_RST;
            r_cfg_report  <= pomppt_pkg::REPORT_INTERVAL_RST;
            r_cfg_step    <= pomppt_pkg::VOLTAGE_STEP_RST;
            r_cfg_islope  <= pomppt_pkg::SLOPE_RST;
            r_cfg_ioffset <= '0;
            r_cfg_vslope  <= pomppt_pkg::SLOPE_RST;
            r_cfg_voffset <= '0;
            for (int c = 0; c < NUM_CHANNELS; c++) begin
                r_last_trk[c] <= '0;
                r_last_rep[c] <= '0;
                r_dac[c]      <= '0;
                r_prev_dac[c] <= '0;
                r_ref_pwr[c]  <= '0;
                r_cnt[c]      <= '0;
                r_vavg[c]     <= '0;
                r_iavg[c]     <= '0;
                r_vlow[c]     <= '1;
                r_vhigh[c]    <= '0;
                r_ilow[c]     <= '1;
                r_ihigh[c]    <= '0;
            end
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                unique case (pomppt_pkg::t_cfg_reg'(i_cfg_index))
                    pomppt_pkg::CFG_TRACK_INTERVAL:  r_cfg_track   <= i_cfg_data[15:0];
                    pomppt_pkg::CFG_REPORT_INTERVAL: r_cfg_report  <= i_cfg_data[15:0];
                    pomppt_pkg::CFG_VOLTAGE_STEP:    r_cfg_step    <= i_cfg_data[11:0];
                    pomppt_pkg::CFG_CURRENT_SLOPE:   r_cfg_islope  <= i_cfg_data;
                    pomppt_pkg::CFG_CURRENT_OFFSET:  r_cfg_ioffset <= i_cfg_data;
                    pomppt_pkg::CFG_VOLTAGE_SLOPE:   r_cfg_vslope  <= i_cfg_data;
                    pomppt_pkg::CFG_VOLTAGE_OFFSET:  r_cfg_voffset <= i_cfg_data;
                    default: ;
                endcase
            end

            unique case (r_state)
                pomppt_pkg::S_IDLE: begin
                    if (i_valid) begin
                        r_op      <= pomppt_pkg::t_op'(i_operation);
                        r_chan_in <= i_channel;
                        r_time    <= i_time_ms;
                        r_icode   <= i_current_code;
                        r_scode   <= i_set_code;
                    end
                end
                pomppt_pkg::S_DECODE: begin
                    if (w_in_range) begin
                        if (r_op == pomppt_pkg::OP_SET) begin
                            r_dac[w_ch] <= w_set_code;
                            r_res_dac   <= w_set_code;
                            r_res_rep   <= 1'b0;
                            r_res_mv    <= '0;
                            r_res_mi    <= '0;
                            r_res_vlo   <= '0;
                            r_res_vhi   <= '0;
                            r_res_ilo   <= '0;
                            r_res_ihi   <= '0;
                        end else if (!w_early) begin
                            r_last_trk[w_ch] <= r_time;
                            r_v     <= r_dac[w_ch];
                            r_prev  <= r_prev_dac[w_ch];
                            r_ref   <= r_ref_pwr[w_ch];
                            r_n     <= r_cnt[w_ch];
                            r_avg_v <= r_vavg[w_ch];
                            r_avg_i <= r_iavg[w_ch];
                            r_vlo   <= r_vlow[w_ch];
                            r_vhi   <= r_vhigh[w_ch];
                            r_ilo   <= r_ilow[w_ch];
                            r_ihi   <= r_ihigh[w_ch];
                        end
                    end
                end
                pomppt_pkg::S_SCALE_I: r_cur  <= w_cur_full;
                pomppt_pkg::S_SCALE_V: r_vol  <= w_vol_full;
                pomppt_pkg::S_POWER:   r_pw   <= w_pw;
                pomppt_pkg::S_DIFF:    r_diff <= $unsigned(r_ref) - $unsigned(r_pw);
                pomppt_pkg::S_DECIDE: begin
                    r_num_v <= w_num_v;
                    priority if (w_same) begin
                        r_up     <= 1'b0;
                        r_ref_we <= 1'b0;
                    end else if (r_pw >= r_ref) begin
                        r_up     <= w_rising;
                        r_ref_we <= 1'b1;
                    end else if (w_large) begin
                        r_up     <= !w_rising;
                        r_ref_we <= 1'b1;
                    end else begin
                        r_up     <= w_rising;
                        r_ref_we <= 1'b0;
                    end
                end
                pomppt_pkg::S_NUMER: r_num_i <= w_num_i;
                pomppt_pkg::S_UPDATE: begin
                    r_vavg[w_ch]     <= w_avg_v_new;
                    r_iavg[w_ch]     <= w_avg_i_new;
                    r_prev_dac[w_ch] <= r_v;
                    r_dac[w_ch]      <= w_next;
                    if (r_ref_we) r_ref_pwr[w_ch] <= r_pw;
                    r_res_dac <= w_next;
                    r_res_rep <= w_report;
                    if (w_report) begin
                        // report the stats including this sample, then clear
                        r_last_rep[w_ch] <= r_time;
                        r_vlow[w_ch]     <= '1;
                        r_vhigh[w_ch]    <= '0;
                        r_ilow[w_ch]     <= '1;
                        r_ihigh[w_ch]    <= '0;
                        r_cnt[w_ch]      <= '0;
                        r_res_mv  <= w_avg_v_new;
                        r_res_mi  <= w_avg_i_new;
                        r_res_vlo <= w_vlo_new;
                        r_res_vhi <= w_vhi_new;
                        r_res_ilo <= w_ilo_new;
                        r_res_ihi <= w_ihi_new;
                    end else begin
                        r_vlow[w_ch]  <= w_vlo_new;
                        r_vhigh[w_ch] <= w_vhi_new;
                        r_ilow[w_ch]  <= w_ilo_new;
                        r_ihigh[w_ch] <= w_ihi_new;
                        r_cnt[w_ch]   <= r_n + 1'b1;
                        r_res_mv  <= '0;
                        r_res_mi  <= '0;
                        r_res_vlo <= '0;
                        r_res_vhi <= '0;
                        r_res_ilo <= '0;
                        r_res_ihi <= '0;
                    end
                end
                default: ;
            endcase

            // output register
            if (w_emit) begin
                r_o_valid <= 1'b1;
                r_out_ch  <= r_chan_in;
                r_out_dac <= r_res_dac;
                r_out_rep <= r_res_rep;
                r_out_mv  <= r_res_mv;
                r_out_mi  <= r_res_mi;
                r_out_vlo <= r_res_vlo;
                r_out_vhi <= r_res_vhi;
                r_out_ilo <= r_res_ilo;
                r_out_ihi <= r_res_ihi;
            end else if (r_o_valid && !i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    assign o_valid        = r_o_valid;
    assign o_out_channel  = r_out_ch;
    assign o_dac_code     = 12'(r_out_dac);
    assign o_report_valid = r_out_rep;
    assign o_mean_voltage = 12'(r_out_mv);
    assign o_mean_current = 12'(r_out_mi);
    assign o_min_voltage  = 12'(r_out_vlo);
    assign o_max_voltage  = 12'(r_out_vhi);
    assign o_min_current  = 12'(r_out_ilo);
    assign o_max_current  = 12'(r_out_ihi);

endmodule

`default_nettype wire

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the perturb-and-observe MPPT tracker: directed table
// of samples, then randomized sample sequences, compared against an internal
// tracker model through a queue of expected results.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

    localparam int NCH       = 8;
    localparam int WDOG_MAX  = 20000;
    localparam int DRAIN_CYC = 200;

    typedef struct packed {
        logic [2:0]  chan;
        logic [11:0] dac;
        logic        rpt;
        logic [11:0] mv, mc, vlo, vhi, clo, chi;
    } t_result;

    typedef struct {
        pomppt_pkg::t_op op;
        logic [2:0]  chan;
        logic [31:0] tms;
        logic [11:0] icode;
        logic [11:0] scode;
        bit          fixed;   // expected result typed in below
        bit          has_res;
        t_result     res;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    logic i_operation = 1'b0;
    logic [2:0] i_channel = '0;
    logic [31:0] i_time_ms = '0;
    logic [11:0] i_current_code = '0;
    logic [11:0] i_set_code = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    logic [2:0] o_out_channel;
    logic [11:0] o_dac_code, o_mean_voltage, o_mean_current;
    logic [11:0] o_min_voltage, o_max_voltage, o_min_current, o_max_current;
    logic o_report_valid;
    logic i_cfg_we = 1'b0;
    logic [pomppt_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [pomppt_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    always #5 i_clk = ~i_clk;

    perturb_observe_mppt_tracker u_top (.*);

    // ---------------- tracker model state ----------------
    logic [15:0] m_track_iv, m_report_iv;
    logic [11:0] m_vstep;
    logic signed [31:0] m_islope, m_ioffs, m_vslope, m_voffs;
    logic [31:0] m_last_trk [NCH];
    logic [31:0] m_last_rpt [NCH];
    logic [11:0] m_dac [NCH];
    logic [11:0] m_prev_dac [NCH];
    logic signed [63:0] m_ref [NCH];
    logic [15:0] m_count [NCH];
    logic [11:0] m_vavg [NCH], m_cavg [NCH];
    logic [11:0] m_vlo [NCH], m_vhi [NCH], m_clo [NCH], m_chi [NCH];

    t_result result_q[$];
    int  n_err = 0;
    int  n_results = 0, n_reports = 0, n_items = 0;
    int  idle_in = 0, idle_out = 0;   // percent idle per side

    task automatic model_reset();
        m_track_iv = pomppt_pkg::TRACK_INTERVAL_RST;
        m_report_iv = pomppt_pkg::REPORT_INTERVAL_RST;
        m_vstep = pomppt_pkg::VOLTAGE_STEP_RST;
        m_islope = pomppt_pkg::SLOPE_RST; m_ioffs = '0;
        m_vslope = pomppt_pkg::SLOPE_RST; m_voffs = '0;
        for (int c = 0; c < NCH; c++) begin
            m_last_trk[c] = '0; m_last_rpt[c] = '0; m_dac[c] = '0;
            m_prev_dac[c] = '0; m_ref[c] = '0; m_count[c] = '0;
            m_vavg[c] = '0; m_cavg[c] = '0;
            m_vlo[c] = '1; m_vhi[c] = '0; m_clo[c] = '1; m_chi[c] = '0;
        end
    endtask

    // floor(a*b / 2^24) saturated to 64-bit signed
    function automatic logic signed [63:0] power_q16(logic signed [63:0] a,
                                                     logic signed [63:0] b);
        logic signed [127:0] p, q;
        p = 128'(a) * 128'(b);
        q = p >>> pomppt_pkg::ROUND_BITS;
        if (q > 128'(pomppt_pkg::PWR_MAX)) return pomppt_pkg::PWR_MAX;
        if (q < 128'(pomppt_pkg::PWR_MIN)) return pomppt_pkg::PWR_MIN;
        return q[63:0];
    endfunction

    // Predict one transaction; returns 1 when a result is produced.
    function automatic bit track_predict(t_row r, output t_result res);
        int unsigned c, v, n, ic;
        logic signed [63:0] cur, vol, pw, rf, nxt;
        logic [63:0] diff;
        int dir, sgn;
        bit big_fall;
        res = '0;
        c = r.chan;
        res.chan = r.chan;
        if (r.op == pomppt_pkg::OP_SET) begin
            m_dac[c] = r.scode;
            res.dac = r.scode;
            return 1;
        end
        if ((r.tms - m_last_trk[c]) < 32'(m_track_iv)) return 0;
        m_last_trk[c] = r.tms;
        v = m_dac[c]; ic = r.icode;
        cur = 64'(ic) * 64'(m_islope) + 64'(m_ioffs);
        vol = 64'(v) * 64'(m_vslope) + 64'(m_voffs);
        pw = power_q16(cur, vol);
        rf = m_ref[c];
        sgn = (v > m_prev_dac[c]) ? 1 : -1;
        if (v == m_prev_dac[c]) dir = -1;
        else if (pw >= rf) begin
            m_ref[c] = pw; dir = sgn;
        end else begin
            diff = 64'(rf) - 64'(pw);
            if (rf == 0) big_fall = 1;
            else if (rf < 0) big_fall = 0;
            else big_fall = diff > (64'(rf) / 10);
            if (big_fall) begin
                m_ref[c] = pw; dir = -sgn;
            end else dir = sgn;
        end
        // running stats, 32-bit arithmetic
        n = m_count[c];
        m_vavg[c] = 12'((32'(m_vavg[c]) * n + v) / (n + 1));
        m_cavg[c] = 12'((32'(m_cavg[c]) * n + ic) / (n + 1));
        if (v > m_vhi[c]) m_vhi[c] = 12'(v);
        if (v < m_vlo[c]) m_vlo[c] = 12'(v);
        if (ic > m_chi[c]) m_chi[c] = 12'(ic);
        if (ic < m_clo[c]) m_clo[c] = 12'(ic);
        m_count[c] = 16'(n + 1);
        if ((r.tms - m_last_rpt[c]) > 32'(m_report_iv)) begin
            m_last_rpt[c] = r.tms;
            res.rpt = 1'b1;
            res.mv = m_vavg[c]; res.mc = m_cavg[c];
            res.vlo = m_vlo[c]; res.vhi = m_vhi[c];
            res.clo = m_clo[c]; res.chi = m_chi[c];
            m_vlo[c] = '1; m_vhi[c] = '0; m_clo[c] = '1; m_chi[c] = '0;
            m_count[c] = '0;
        end
        m_prev_dac[c] = 12'(v);
        nxt = 64'(v) + 64'(dir) * 64'(m_vstep);
        if (nxt < 0) nxt = 0;
        if (nxt > 4095) nxt = 4095;
        m_dac[c] = nxt[11:0];
        res.dac = nxt[11:0];
        return 1;
    endfunction

    // ---------------- result checker ----------------
    always @(posedge i_clk) begin
        t_result got, exp_r;
        if (i_rst_n && o_valid && !i_stall) begin
            got = '{o_out_channel, o_dac_code, o_report_valid, o_mean_voltage,
                    o_mean_current, o_min_voltage, o_max_voltage,
                    o_min_current, o_max_current};
            if (result_q.size() == 0) begin
                $error("unexpected result: channel %0d dac %0d",
                       o_out_channel, o_dac_code);
                n_err++;
            end else begin
                exp_r = result_q.pop_front();
                n_results++;
                if (exp_r.rpt) n_reports++;
                if (got.chan != exp_r.chan) begin
                    $error("out_channel exp %0d got %0d", exp_r.chan, got.chan); n_err++;
                end
                if (got.dac != exp_r.dac) begin
                    $error("dac_code exp %0d got %0d", exp_r.dac, got.dac); n_err++;
                end
                if (got.rpt != exp_r.rpt) begin
                    $error("report_valid exp %0d got %0d", exp_r.rpt, got.rpt); n_err++;
                end
                if (got.mv != exp_r.mv) begin
                    $error("mean_voltage exp %0d got %0d", exp_r.mv, got.mv); n_err++;
                end
                if (got.mc != exp_r.mc) begin
                    $error("mean_current exp %0d got %0d", exp_r.mc, got.mc); n_err++;
                end
                if (got.vlo != exp_r.vlo) begin
                    $error("min_voltage exp %0d got %0d", exp_r.vlo, got.vlo); n_err++;
                end
                if (got.vhi != exp_r.vhi) begin
                    $error("max_voltage exp %0d got %0d", exp_r.vhi, got.vhi); n_err++;
                end
                if (got.clo != exp_r.clo) begin
                    $error("min_current exp %0d got %0d", exp_r.clo, got.clo); n_err++;
                end
                if (got.chi != exp_r.chi) begin
                    $error("max_current exp %0d got %0d", exp_r.chi, got.chi); n_err++;
                end
            end
        end
    end

    // Receiver stall, redrawn every cycle
    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < idle_out);
    end

    // Watchdog: cycles without any accepted transaction on either side
    int wdog = 0;
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || !i_rst_n) wdog <= 0;
        else wdog <= wdog + 1;
        if (wdog == WDOG_MAX) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    // ---------------- driving ----------------
    task automatic cfg_write(pomppt_pkg::t_cfg_reg idx, logic [31:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1; i_cfg_index <= idx; i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            pomppt_pkg::CFG_TRACK_INTERVAL:  m_track_iv  = val[15:0];
            pomppt_pkg::CFG_REPORT_INTERVAL: m_report_iv = val[15:0];
            pomppt_pkg::CFG_VOLTAGE_STEP:    m_vstep     = val[11:0];
            pomppt_pkg::CFG_CURRENT_SLOPE:   m_islope    = val;
            pomppt_pkg::CFG_CURRENT_OFFSET:  m_ioffs     = val;
            pomppt_pkg::CFG_VOLTAGE_SLOPE:   m_vslope    = val;
            pomppt_pkg::CFG_VOLTAGE_OFFSET:  m_voffs     = val;
            default: ;
        endcase
    endtask

    // Send one transaction; prediction is pushed when it is accepted.
    task automatic send_item(t_row r);
        t_result res;
        bit got;
        while ($urandom_range(99) < idle_in) begin
            @(posedge i_clk);
            i_valid <= 1'b0;
        end
        @(posedge i_clk);
        i_valid <= 1'b1; i_operation <= r.op; i_channel <= r.chan;
        i_time_ms <= r.tms; i_current_code <= r.icode; i_set_code <= r.scode;
        do @(posedge i_clk); while (o_stall);
        // accepted at this edge; drop valid until the next item is sent
        i_valid <= 1'b0;
        got = track_predict(r, res);
        if (r.fixed && (got != r.has_res || (got && res != r.res))) begin
            $error("directed row mismatch: channel %0d dac exp %0d model %0d",
                   r.chan, r.res.dac, res.dac);
            n_err++;
        end
        if (got) result_q.push_back(res);
        n_items++;
    endtask

    // Wait for all results, then the latency of a possible dropped sample.
    task automatic drain();
        while (result_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
    endtask

    function automatic t_row mk(pomppt_pkg::t_op op, int ch, logic [31:0] t,
                                int ic, int sc);
        t_row r;
        r.op = op; r.chan = 3'(ch); r.tms = t; r.icode = 12'(ic); r.scode = 12'(sc);
        r.fixed = 0; r.has_res = 0; r.res = '0;
        return r;
    endfunction

    function automatic t_row fx(t_row r, bit has, t_result res);
        r.fixed = 1; r.has_res = has; r.res = res;
        return r;
    endfunction

    // Random run over all channels: mostly advancing time stamps, some direct sets.
    task automatic random_burst(int count, int tstep_max);
        logic [31:0] tnow [NCH];
        t_row r;
        int c;
        for (int k = 0; k < NCH; k++) tnow[k] = $urandom;
        for (int k = 0; k < count; k++) begin
            c = $urandom_range(NCH - 1);
            if ($urandom_range(99) < 8)
                r = mk(pomppt_pkg::OP_SET, c, $urandom, $urandom, $urandom_range(4095));
            else begin
                if ($urandom_range(99) < 10) tnow[c] = $urandom;    // noise
                else tnow[c] += $urandom_range(tstep_max);
                r = mk(pomppt_pkg::OP_TRACK, c, tnow[c], $urandom_range(4095), $urandom);
            end
            send_item(r);
        end
    endtask

    initial begin
        t_row dir_tab[$];
        t_result z;
        model_reset();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part at reset settings (track 100, report 1000, step 1)
        z = '0;
        // direct set echoes the code, no report
        z.chan = 3; z.dac = 4095;
        dir_tab.push_back(fx(mk(pomppt_pkg::OP_SET, 3, 0, 0, 4095), 1, z));
        // too soon after time 0: ignored
        dir_tab.push_back(fx(mk(pomppt_pkg::OP_TRACK, 0, 50, 100, 0), 0, '0));
        // code equal to previous: step -1, saturates at 0
        z = '0; z.chan = 0; z.dac = 0;
        dir_tab.push_back(fx(mk(pomppt_pkg::OP_TRACK, 0, 100, 4095, 0), 1, z));
        // report after the report interval: stats of this sample
        z = '0; z.chan = 1; z.dac = 0; z.rpt = 1;
        z.mv = 0; z.mc = 0; z.vlo = 0; z.vhi = 0; z.clo = 0; z.chi = 0;
        dir_tab.push_back(fx(mk(pomppt_pkg::OP_TRACK, 1, 1001, 0, 0), 1, z));
        // saturation at top, power rise, large fall, zero ref
        dir_tab.push_back(mk(pomppt_pkg::OP_TRACK, 3, 200, 4095, 0));
        dir_tab.push_back(mk(pomppt_pkg::OP_TRACK, 3, 300, 4095, 0));
        dir_tab.push_back(mk(pomppt_pkg::OP_TRACK, 3, 400, 0, 0));
        dir_tab.push_back(mk(pomppt_pkg::OP_TRACK, 3, 500, 2000, 0));
        dir_tab.push_back(mk(pomppt_pkg::OP_TRACK, 3, 600, 1900, 0));
        dir_tab.push_back(mk(pomppt_pkg::OP_SET, 2, 0, 0, 2048));
        dir_tab.push_back(mk(pomppt_pkg::OP_TRACK, 2, 150, 1000, 0));
        dir_tab.push_back(mk(pomppt_pkg::OP_TRACK, 2, 250, 1000, 0));
        dir_tab.push_back(mk(pomppt_pkg::OP_TRACK, 2, 350, 950, 0));
        dir_tab.push_back(mk(pomppt_pkg::OP_TRACK, 2, 450, 800, 0));
        // time wrap
        dir_tab.push_back(mk(pomppt_pkg::OP_TRACK, 7, 32'hFFFF_FFFF, 4095, 0));
        dir_tab.push_back(mk(pomppt_pkg::OP_TRACK, 7, 32'h0000_0063, 1, 0));
        dir_tab.push_back(mk(pomppt_pkg::OP_TRACK, 7, 32'h0000_0200, 2222, 0));
        dir_tab.push_back(mk(pomppt_pkg::OP_TRACK, 2, 2000, 4095, 0));
        foreach (dir_tab[k]) send_item(dir_tab[k]);
        drain();

        // Extreme calibration: saturate power both ways, large steps
        cfg_write(pomppt_pkg::CFG_TRACK_INTERVAL, 0);
        cfg_write(pomppt_pkg::CFG_REPORT_INTERVAL, 0);
        cfg_write(pomppt_pkg::CFG_VOLTAGE_STEP, 4095);
        cfg_write(pomppt_pkg::CFG_CURRENT_SLOPE, 32'h7FFF_FFFF);
        cfg_write(pomppt_pkg::CFG_CURRENT_OFFSET, 32'h8000_0000);
        cfg_write(pomppt_pkg::CFG_VOLTAGE_SLOPE, 32'h8000_0000);
        cfg_write(pomppt_pkg::CFG_VOLTAGE_OFFSET, 32'h7FFF_FFFF);
        random_burst(60, 3);
        drain();

        // Phases with idling patterns and random calibration
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin idle_in = 0;  idle_out = 0;  end
                1: begin idle_in = 59; idle_out = 0;  end
                2: begin idle_in = 0;  idle_out = 59; end
                3: begin idle_in = 23; idle_out = 23; end
                default: begin idle_in = 0; idle_out = 0; end
            endcase
            cfg_write(pomppt_pkg::CFG_TRACK_INTERVAL,
                      (ph == 4) ? 65535 : $urandom_range(20));
            cfg_write(pomppt_pkg::CFG_REPORT_INTERVAL,
                      (ph == 4) ? 65535 : $urandom_range(200));
            cfg_write(pomppt_pkg::CFG_VOLTAGE_STEP,
                      $urandom_range(1) ? $urandom_range(64) : $urandom_range(4095));
            cfg_write(pomppt_pkg::CFG_CURRENT_SLOPE, $urandom);
            cfg_write(pomppt_pkg::CFG_CURRENT_OFFSET, $urandom);
            cfg_write(pomppt_pkg::CFG_VOLTAGE_SLOPE,
                      $urandom_range(1) ? 32'(pomppt_pkg::SLOPE_RST) : $urandom);
            cfg_write(pomppt_pkg::CFG_VOLTAGE_OFFSET, $urandom_range(1) ? 0 : $urandom);
            random_burst(140, 40);
            drain();
        end

        $display("tb: %0d transactions sent, %0d results checked (%0d reports)",
                 n_items, n_results, n_reports);
        $display("tb: covered reset and extreme calibrations, time wrap, four idling modes");
        if (n_err == 0) $display("tb: PASS");
        else $display("tb: FAIL");
        $finish;
    end
endmodule

`default_nettype wire
